FILE: design/jlspg_pkg.sv
package jlspg_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;

  typedef struct packed {
    logic        forward;
    logic [31:0] delay;
    logic [31:0] count;
    logic [63:0] jerk;
    logic [63:0] accel;
    logic [63:0] speed;
    logic [63:0] phase;
  } seg_t;

  typedef struct packed {
    logic push;
    seg_t seg;
  } cmd_t;

  typedef struct packed {
    logic        pulse;
    logic [31:0] position;
    logic        dir_level;
    logic        busy;
    logic        accepted;
  } res_t;

endpackage

FILE: design/jlspg_front.sv
module jlspg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                operation,
  input  logic signed [1:0]   seg_direction,
  input  logic        [31:0]  seg_start_delay,
  input  logic        [31:0]  seg_pulse_count,
  input  logic signed [63:0]  seg_jerk,
  input  logic signed [63:0]  seg_accel,
  input  logic        [63:0]  seg_speed,
  input  logic        [63:0]  seg_phase,
  output logic                cmd_valid,
  output jlspg_pkg::cmd_t     cmd,
  input  logic                cmd_take
);

  jlspg_pkg::cmd_t entries [jlspg_pkg::CMD_DEPTH];
  logic [jlspg_pkg::CMD_PTR_W-1:0] wr_ptr;
  logic [jlspg_pkg::CMD_PTR_W-1:0] rd_ptr;
  logic [jlspg_pkg::CMD_PTR_W:0]   cnt;
  jlspg_pkg::cmd_t                 in_cmd;
  logic                            wr_en;
  logic                            rd_en;

  // classify: sign bit clear counts as forward
  always_comb begin
    in_cmd.push          = (operation == jlspg_pkg::OP_PUSH);
    in_cmd.seg.forward   = ~seg_direction[1];
    in_cmd.seg.delay     = seg_start_delay;
    in_cmd.seg.count     = seg_pulse_count;
    in_cmd.seg.jerk      = seg_jerk;
    in_cmd.seg.accel     = seg_accel;
    in_cmd.seg.speed     = seg_speed;
    in_cmd.seg.phase     = seg_phase;
  end

  assign full      = (cnt == (jlspg_pkg::CMD_PTR_W + 1)'(jlspg_pkg::CMD_DEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = entries[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: design/jlspg_back.sv
module jlspg_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            reverse,
  input  logic            cmd_valid,
  input  jlspg_pkg::cmd_t cmd,
  output logic            cmd_take,
  output logic            res_valid,
  output jlspg_pkg::res_t res,
  input  logic            res_pop
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_SPD  = 6'b000100,
    S_PHS  = 6'b001000,
    S_TAKE = 6'b010000,
    S_LOAD = 6'b100000
  } state_t;

  state_t state;

  jlspg_pkg::seg_t seg_mem [QUEUE_DEPTH];
  jlspg_pkg::seg_t rd_data;
  logic            mem_we;
  logic [IW-1:0]   tail;
  logic [IW+1:0]   tail_sum;
  logic [IW-1:0]   head;
  logic [IW-1:0]   head_inc;
  logic [FW-1:0]   fill;

  logic            active_valid;
  logic            active_forward;
  logic [31:0]     active_delay;
  logic [31:0]     active_count;
  logic [63:0]     active_jerk;
  logic [63:0]     active_accel;
  logic [63:0]     active_speed;
  logic [63:0]     active_phase;
  logic [31:0]     step_position;
  logic            pend_pulse;

  logic            start;
  logic [64:0]     phase_sum;
  logic            carry;
  logic [31:0]     count_after;
  logic [31:0]     position_after;
  logic            has_room;
  logic            queue_empty;

  assign start       = (state == S_IDLE) && cmd_valid && (!res_valid || res_pop);
  assign cmd_take    = start;
  assign queue_empty = (fill == '0);
  assign has_room    = (fill < FW'(QUEUE_DEPTH));

  always_comb begin
    tail_sum = (IW + 2)'(head) + (IW + 2)'(fill);
    if (tail_sum >= (IW + 2)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (IW + 2)'(QUEUE_DEPTH);
    end
    tail     = tail_sum[IW-1:0];
    head_inc = (head == IW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  end

  always_comb begin
    phase_sum      = {1'b0, active_phase} + {1'b0, active_speed};
    carry          = phase_sum[64];
    count_after    = carry ? active_count - 32'd1 : active_count;
    position_after = step_position;
    if (carry) begin
      position_after = step_position + (active_forward ? 32'd1 : 32'hFFFF_FFFF);
    end
  end

  assign mem_we = start && cmd.push && active_valid && has_room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[tail] <= cmd.seg;
    end
    rd_data <= seg_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      fill           <= '0;
      active_valid   <= 1'b0;
      active_forward <= 1'b1;
      active_delay   <= '0;
      active_count   <= '0;
      active_jerk    <= '0;
      active_accel   <= '0;
      active_speed   <= '0;
      active_phase   <= '0;
      step_position  <= '0;
      pend_pulse     <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            res.pulse    <= 1'b0;
            res.position <= step_position;
            res.accepted <= 1'b0;
            res.dir_level <= active_forward ^ reverse;
            if (cmd.push) begin
              res_valid    <= 1'b1;
              res.busy     <= 1'b1;
              res.accepted <= !active_valid || has_room;
              if (!active_valid) begin
                active_valid   <= 1'b1;
                active_forward <= cmd.seg.forward;
                active_delay   <= cmd.seg.delay;
                active_count   <= cmd.seg.count;
                active_jerk    <= cmd.seg.jerk;
                active_accel   <= cmd.seg.accel;
                active_speed   <= cmd.seg.speed;
                active_phase   <= cmd.seg.phase;
                res.dir_level  <= cmd.seg.forward ^ reverse;
              end else if (has_room) begin
                fill <= fill + 1'b1;
              end
            end else if (!active_valid) begin
              res_valid <= 1'b1;
              res.busy  <= 1'b0;
            end else if (active_delay != '0) begin
              active_delay <= active_delay - 32'd1;
              res_valid    <= 1'b1;
              res.busy     <= 1'b1;
            end else if (active_count != '0) begin
              state <= S_ACC;
            end else begin
              pend_pulse <= 1'b0;
              if (!queue_empty) begin
                state <= S_TAKE;
              end else begin
                active_valid <= 1'b0;
                res_valid    <= 1'b1;
                res.busy     <= 1'b0;
              end
            end
          end
        end
        S_ACC: begin
          active_accel <= active_accel + active_jerk;
          state        <= S_SPD;
        end
        S_SPD: begin
          active_speed <= active_speed + active_accel;
          state        <= S_PHS;
        end
        S_PHS: begin
          active_phase  <= phase_sum[63:0];
          active_count  <= count_after;
          step_position <= position_after;
          pend_pulse    <= carry;
          res.pulse     <= carry;
          res.position  <= position_after;
          res.dir_level <= active_forward ^ reverse;
          res.accepted  <= 1'b0;
          if (count_after != '0) begin
            res_valid <= 1'b1;
            res.busy  <= 1'b1;
            state     <= S_IDLE;
          end else if (!queue_empty) begin
            state <= S_TAKE;
          end else begin
            active_valid <= 1'b0;
            res_valid    <= 1'b1;
            res.busy     <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_TAKE: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          active_forward <= rd_data.forward;
          active_delay   <= rd_data.delay;
          active_count   <= rd_data.count;
          active_jerk    <= rd_data.jerk;
          active_accel   <= rd_data.accel;
          active_speed   <= rd_data.speed;
          active_phase   <= rd_data.phase;
          head           <= head_inc;
          fill           <= fill - 1'b1;
          res_valid      <= 1'b1;
          res.pulse      <= pend_pulse;
          res.position   <= step_position;
          res.dir_level  <= rd_data.forward ^ reverse;
          res.busy       <= 1'b1;
          res.accepted   <= 1'b0;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("segment queue overfilled");

  a_take_load: assert property (@(posedge clk) disable iff (rst)
    state == S_TAKE |=> state == S_LOAD)
    else $error("fetch not followed by load");

  a_busy_active: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> active_valid)
    else $error("engine running without an active segment");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_TAKE |-> !queue_empty)
    else $error("fetch from empty segment queue");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_pop |=> res_valid && $stable(res))
    else $error("waiting result changed");

endmodule

FILE: design/jerk_limited_step_pulse_generator_top.sv
// Jerk-limited step pulse generator, one stepper axis.
// Input queue: drive the item on the operation and seg_* ports with push high;
// the transaction completes on a clock edge where full is low. operation low
// is a timer tick, high pushes a motion segment into the segment queue.
// Result queue: while empty is low the oldest result is on step_pulse,
// position, direction_level, busy_res and push_accepted; pop takes it.
// Config: cfg_data sets the axis reverse flag on cfg_valid (always ready);
// write it only with no transaction in flight.
// Sequencing: a push or a non-stepping tick gives its result from the start
// state, or through the take and load states when a finished segment fetches
// the next one from the queue; a stepping tick gives it after the accel, speed
// and phase adder states, and after take and load too when it also fetches.
// The sequencer handles one item at a time and takes the next only once its
// result is out; load waits on the registered segment queue read.
// A two-entry command queue keeps accepting while the sequencer works.
// If pop stays low the result register holds, the sequencer stalls, and full
// rises once the command queue fills. Reset clears the queues and the active
// segment, sets position to zero and direction forward; the reverse flag clears.
module jerk_limited_step_pulse_generator_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               operation,
  input  logic signed [1:0]  seg_direction,
  input  logic        [31:0] seg_start_delay,
  input  logic        [31:0] seg_pulse_count,
  input  logic signed [63:0] seg_jerk,
  input  logic signed [63:0] seg_accel,
  input  logic        [63:0] seg_speed,
  input  logic        [63:0] seg_phase,
  output logic               empty,
  input  logic               pop,
  output logic               step_pulse,
  output logic signed [31:0] position,
  output logic               direction_level,
  output logic               busy_res,
  output logic               push_accepted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic            reverse_direction;
  logic            cmd_valid;
  jlspg_pkg::cmd_t cmd;
  logic            cmd_take;
  logic            res_valid;
  jlspg_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      reverse_direction <= cfg_data;
    end
  end

  jlspg_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .operation       (operation),
    .seg_direction   (seg_direction),
    .seg_start_delay (seg_start_delay),
    .seg_pulse_count (seg_pulse_count),
    .seg_jerk        (seg_jerk),
    .seg_accel       (seg_accel),
    .seg_speed       (seg_speed),
    .seg_phase       (seg_phase),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take)
  );

  jlspg_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .reverse   (reverse_direction),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty           = !res_valid;
  assign step_pulse      = res.pulse;
  assign position        = signed'(res.position);
  assign direction_level = res.dir_level;
  assign busy_res        = res.busy;
  assign push_accepted   = res.accepted;

endmodule
